// File: rtl/jsu_pkg.sv
// Shared types, constants and helper functions for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  // Depth of the job queue between the parser and the output stage.
  localparam int QUEUE_DEPTH_DEF = 4;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_BODY   = 4'd1,
    PH_ESC    = 4'd2,
    PH_HEXHI  = 4'd3,
    PH_WANTBS = 4'd4,
    PH_WANTU  = 4'd5,
    PH_HEXLO  = 4'd6
  } phase_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Error codes.
  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_EXPECT_QUOTE  = 4'd0;
  localparam logic [3:0] ERR_UNTERMINATED  = 4'd1;
  localparam logic [3:0] ERR_RAW_NEWLINE   = 4'd2;
  localparam logic [3:0] ERR_UNTERM_ESC    = 4'd3;
  localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd4;
  localparam logic [3:0] ERR_TRUNC_U       = 4'd5;
  localparam logic [3:0] ERR_BAD_HEX       = 4'd6;
  localparam logic [3:0] ERR_LONE_HIGH     = 4'd7;
  localparam logic [3:0] ERR_INVALID_LOW   = 4'd8;
  localparam logic [3:0] ERR_LONE_LOW      = 4'd9;

  // Source characters of interest.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // Surrogate ranges.
  localparam logic [15:0] HIGH_SUR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SUR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SUR_MAX  = 16'hDFFF;

  // One job: everything a single input item produces, up to four result items.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    kind_t           kind;
    logic [3:0]      code;
  } job_t;

  // Hex digit value; bit 4 set means the byte is not a hex digit.
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end else begin
      v = 5'h10;
    end
    return v;
  endfunction

  // Simple escape decode; bit 8 set means the escape is one of the simple ones.
  function automatic logic [8:0] simple_escape(logic [7:0] c);
    logic [8:0] r;
    unique case (c) inside
      CH_QUOTE, CH_BSLASH, CH_SLASH: r = {1'b1, c};
      CH_LOW_B: r = {1'b1, 8'h08};
      CH_LOW_F: r = {1'b1, 8'h0C};
      CH_LOW_N: r = {1'b1, 8'h0A};
      CH_LOW_R: r = {1'b1, 8'h0D};
      CH_LOW_T: r = {1'b1, 8'h09};
      default:  r = 9'h000;
    endcase
    return r;
  endfunction

  // Job carrying one code point as UTF-8.
  function automatic job_t utf8_job(logic [20:0] cp);
    job_t j;
    j = '0;
    j.kind = KIND_DATA;
    j.code = ERR_NONE;
    if (cp <= 21'h00007F) begin
      j.bytes[0] = cp[7:0];
      j.last_idx = 2'd0;
    end else if (cp <= 21'h0007FF) begin
      j.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      j.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      j.last_idx = 2'd1;
    end else if (cp <= 21'h00FFFF) begin
      j.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
      j.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      j.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      j.last_idx = 2'd2;
    end else begin
      j.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
      j.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      j.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      j.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
      j.last_idx = 2'd3;
    end
    return j;
  endfunction

  // Job carrying a single plain byte.
  function automatic job_t byte_job(logic [7:0] b);
    job_t j;
    j = '0;
    j.kind = KIND_DATA;
    j.bytes[0] = b;
    return j;
  endfunction

  // Job carrying a status result.
  function automatic job_t status_job(kind_t k, logic [3:0] code);
    job_t j;
    j = '0;
    j.kind = k;
    j.code = code;
    return j;
  endfunction

endpackage

// File: rtl/jsu_front.sv
// Parser front end: tracks the string phase and turns each source byte into a job.
`timescale 1ns / 1ps

module jsu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              end_of_text,
  output logic              job_push,
  output jsu_pkg::job_t     job
);

  jsu_pkg::phase_t phase, phase_next;
  logic [15:0]     hex_accum, hex_accum_next;
  logic [1:0]      hex_count, hex_count_next;
  logic [9:0]      high_half, high_half_next;

  logic [4:0]  hex_d;
  logic        is_hex;
  logic [15:0] hex_word;
  logic        hex_done;
  logic        word_high;
  logic        word_low;
  logic [8:0]  esc;
  logic [20:0] pair_cp;

  // Shared decode of the current byte.
  assign hex_d     = jsu_pkg::hex_value(in_byte);
  assign is_hex    = ~hex_d[4];
  assign hex_word  = {hex_accum[11:0], hex_d[3:0]};
  assign hex_done  = (hex_count == 2'd3);
  assign word_high = (hex_word >= jsu_pkg::HIGH_SUR_MIN) && (hex_word <= jsu_pkg::HIGH_SUR_MAX);
  assign word_low  = (hex_word >= jsu_pkg::LOW_SUR_MIN) && (hex_word <= jsu_pkg::LOW_SUR_MAX);
  assign esc       = jsu_pkg::simple_escape(in_byte);
  assign pair_cp   = 21'h010000 + {1'b0, high_half, 10'b0} + {11'b0, hex_word[9:0]};

  // Next phase and decoder registers.
  always_comb begin
    phase_next     = phase;
    hex_accum_next = hex_accum;
    hex_count_next = hex_count;
    high_half_next = high_half;
    unique case (phase) inside
      jsu_pkg::PH_BODY: begin
        if (end_of_text || in_byte == jsu_pkg::CH_QUOTE || in_byte == jsu_pkg::CH_NL) begin
          phase_next = jsu_pkg::PH_IDLE;
        end else if (in_byte == jsu_pkg::CH_BSLASH) begin
          phase_next = jsu_pkg::PH_ESC;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (end_of_text) begin
          phase_next = jsu_pkg::PH_IDLE;
        end else if (in_byte == jsu_pkg::CH_LOW_U) begin
          phase_next     = jsu_pkg::PH_HEXHI;
          hex_accum_next = '0;
          hex_count_next = '0;
        end else if (esc[8]) begin
          phase_next = jsu_pkg::PH_BODY;
        end else begin
          phase_next = jsu_pkg::PH_IDLE;
        end
      end
      jsu_pkg::PH_HEXHI, jsu_pkg::PH_HEXLO: begin
        if (end_of_text || !is_hex) begin
          phase_next = jsu_pkg::PH_IDLE;
        end else if (!hex_done) begin
          hex_accum_next = hex_word;
          hex_count_next = hex_count + 2'd1;
        end else begin
          hex_accum_next = '0;
          hex_count_next = '0;
          if (phase == jsu_pkg::PH_HEXHI) begin
            if (word_high) begin
              high_half_next = hex_word[9:0];
              phase_next     = jsu_pkg::PH_WANTBS;
            end else if (word_low) begin
              phase_next = jsu_pkg::PH_IDLE;
            end else begin
              phase_next = jsu_pkg::PH_BODY;
            end
          end else begin
            if (word_low) begin
              high_half_next = '0;
              phase_next     = jsu_pkg::PH_BODY;
            end else begin
              phase_next = jsu_pkg::PH_IDLE;
            end
          end
        end
      end
      jsu_pkg::PH_WANTBS: begin
        phase_next = (end_of_text || in_byte != jsu_pkg::CH_BSLASH) ? jsu_pkg::PH_IDLE
                                                                    : jsu_pkg::PH_WANTU;
      end
      jsu_pkg::PH_WANTU: begin
        if (end_of_text || in_byte != jsu_pkg::CH_LOW_U) begin
          phase_next = jsu_pkg::PH_IDLE;
        end else begin
          phase_next     = jsu_pkg::PH_HEXLO;
          hex_accum_next = '0;
          hex_count_next = '0;
        end
      end
      default: begin
        phase_next = (!end_of_text && in_byte == jsu_pkg::CH_QUOTE) ? jsu_pkg::PH_BODY
                                                                    : jsu_pkg::PH_IDLE;
      end
    endcase
    // Entering idle on an error or a done clears the decoder, as does a fresh string.
    if (phase_next == jsu_pkg::PH_IDLE ||
        (phase_next == jsu_pkg::PH_BODY && phase != jsu_pkg::PH_BODY &&
         phase != jsu_pkg::PH_ESC && phase != jsu_pkg::PH_HEXHI &&
         phase != jsu_pkg::PH_HEXLO)) begin
      hex_accum_next = '0;
      hex_count_next = '0;
      high_half_next = '0;
    end
  end

  // Job produced by the current byte.
  always_comb begin
    job_push = 1'b0;
    job      = '0;
    unique case (phase) inside
      jsu_pkg::PH_BODY: begin
        job_push = 1'b1;
        if (end_of_text) begin
          job = jsu_pkg::status_job(jsu_pkg::KIND_ERR, jsu_pkg::ERR_UNTERMINATED);
        end else if (in_byte == jsu_pkg::CH_QUOTE) begin
          job = jsu_pkg::status_job(jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE);
        end else if (in_byte == jsu_pkg::CH_NL) begin
          job = jsu_pkg::status_job(jsu_pkg::KIND_ERR, jsu_pkg::ERR_RAW_NEWLINE);
        end else if (in_byte == jsu_pkg::CH_BSLASH) begin
          job_push = 1'b0;
        end else begin
          job = jsu_pkg::byte_job(in_byte);
        end
      end
      jsu_pkg::PH_ESC: begin
        job_push = 1'b1;
        if (end_of_text) begin
          job = jsu_pkg::status_job(jsu_pkg::KIND_ERR, jsu_pkg::ERR_UNTERM_ESC);
        end else if (in_byte == jsu_pkg::CH_LOW_U) begin
          job_push = 1'b0;
        end else if (esc[8]) begin
          job = jsu_pkg::byte_job(esc[7:0]);
        end else begin
          job = jsu_pkg::status_job(jsu_pkg::KIND_ERR, jsu_pkg::ERR_BAD_ESCAPE);
        end
      end
      jsu_pkg::PH_HEXHI, jsu_pkg::PH_HEXLO: begin
        if (end_of_text) begin
          job_push = 1'b1;
          job = jsu_pkg::status_job(jsu_pkg::KIND_ERR, jsu_pkg::ERR_TRUNC_U);
        end else if (!is_hex) begin
          job_push = 1'b1;
          job = jsu_pkg::status_job(jsu_pkg::KIND_ERR, jsu_pkg::ERR_BAD_HEX);
        end else if (hex_done) begin
          if (phase == jsu_pkg::PH_HEXHI) begin
            if (word_low) begin
              job_push = 1'b1;
              job = jsu_pkg::status_job(jsu_pkg::KIND_ERR, jsu_pkg::ERR_LONE_LOW);
            end else if (!word_high) begin
              job_push = 1'b1;
              job = jsu_pkg::utf8_job({5'b0, hex_word});
            end
          end else begin
            job_push = 1'b1;
            if (word_low) begin
              job = jsu_pkg::utf8_job(pair_cp);
            end else begin
              job = jsu_pkg::status_job(jsu_pkg::KIND_ERR, jsu_pkg::ERR_INVALID_LOW);
            end
          end
        end
      end
      jsu_pkg::PH_WANTBS: begin
        if (end_of_text || in_byte != jsu_pkg::CH_BSLASH) begin
          job_push = 1'b1;
          job = jsu_pkg::status_job(jsu_pkg::KIND_ERR, jsu_pkg::ERR_LONE_HIGH);
        end
      end
      jsu_pkg::PH_WANTU: begin
        if (end_of_text || in_byte != jsu_pkg::CH_LOW_U) begin
          job_push = 1'b1;
          job = jsu_pkg::status_job(jsu_pkg::KIND_ERR, jsu_pkg::ERR_LONE_HIGH);
        end
      end
      default: begin
        if (end_of_text || in_byte != jsu_pkg::CH_QUOTE) begin
          job_push = 1'b1;
          job = jsu_pkg::status_job(jsu_pkg::KIND_ERR, jsu_pkg::ERR_EXPECT_QUOTE);
        end
      end
    endcase
    job_push = job_push & accept;
  end

  // State registers advance only on an accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= jsu_pkg::PH_IDLE;
      hex_accum <= '0;
      hex_count <= '0;
      high_half <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      hex_accum <= hex_accum_next;
      hex_count <= hex_count_next;
      high_half <= high_half_next;
    end
  end

endmodule

// File: rtl/jsu_queue.sv
// Small job queue that decouples the parser from the output stage.
`timescale 1ns / 1ps

module jsu_queue #(
  parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  jsu_pkg::job_t wr_job,
  output logic          full,
  input  logic          rd_en,
  output jsu_pkg::job_t rd_job,
  output logic          not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jsu_pkg::job_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_job    = slots[rd_ptr];

  // Storage is written without reset; only pointers and count are control.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // Pointer and occupancy tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CNT_W'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/jsu_back.sv
// Output stage: holds one job and hands out one result item per cycle of pop.
`timescale 1ns / 1ps

module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_not_empty,
  input  jsu_pkg::job_t q_job,
  output logic          q_rd,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic [1:0]    kind,
  output logic [3:0]    error_code,
  output logic          last
);

  jsu_pkg::job_t cur;
  logic          cur_valid;
  logic [1:0]    idx;
  logic          taken;
  logic          final_taken;

  assign empty       = ~cur_valid;
  assign taken       = pop & cur_valid;
  assign last        = (idx == cur.last_idx);
  assign final_taken = taken & last;
  assign q_rd        = q_not_empty & (~cur_valid | final_taken);

  // Result ports show the current item of the held job.
  assign out_byte   = (cur.kind == jsu_pkg::KIND_DATA) ? cur.bytes[idx] : 8'h00;
  assign kind       = cur.kind;
  assign error_code = cur.code;

  // Job holding register with item index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_rd) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (final_taken) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (taken) begin
      idx <= idx + 2'd1;
    end
  end

  // Job payload needs no reset.
  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_job;
    end
  end

endmodule

// File: rtl/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper with UTF-8 output.
`timescale 1ns / 1ps

// The block takes one source byte per item (or an end-of-text marker), waits
// for an opening quote and decodes the JSON string body, emitting each code
// point as one to four UTF-8 byte items, a done item at the closing quote, or
// an error item after which it returns to idle. The parser accepts one item
// every cycle as long as its job queue (QUEUE_DEPTH entries) is not full; the
// output stage delivers one result item per cycle while pop is asserted, so
// an escape that encodes to n UTF-8 bytes gives n result items and the queue
// absorbs such bursts. A result goes through the job queue and the output
// stage's holding register. Bytes that produce no result (the opening
// quote, a backslash, hex digits before the fourth) leave nothing in the queue.
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [3:0] error_code,
  output logic       last
);

  logic          accept;
  logic          job_push;
  jsu_pkg::job_t front_job;
  jsu_pkg::job_t head_job;
  logic          q_not_empty;
  logic          q_rd;

  assign accept = push & ~full;

  // Parser front end.
  jsu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .job_push    (job_push),
    .job         (front_job)
  );

  // Job queue between the two sides.
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (job_push),
    .wr_job    (front_job),
    .full      (full),
    .rd_en     (q_rd),
    .rd_job    (head_job),
    .not_empty (q_not_empty)
  );

  // Output stage.
  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_job       (head_job),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .kind        (kind),
    .error_code  (error_code),
    .last        (last)
  );

endmodule

// File: tb/utf8_unescape_checker.sv
// Checker that predicts and compares the UTF-8 result items of the JSON string unescaper.
`timescale 1ns / 1ps

module utf8_unescape_checker
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic [1:0] kind,
  input  logic [3:0] error_code,
  input  logic       last,
  output int         mismatches,
  output int         pending_results
);

  // One decoded result item as it should appear on the output ports.
  typedef struct {
    logic [7:0] out_byte;
    kind_t      kind;
    logic [3:0] code;
    logic       last;
  } unescaped_result_t;

  // Decoder state, mirrored from the source text seen so far.
  phase_t            parse_phase;
  logic [15:0]       digit_accum;
  logic [1:0]        digit_count;
  logic [9:0]        high_bits;
  unescaped_result_t awaited_q[$];
  int                step_results;

  // Value of a hex digit; bit 4 is set for a byte that is not one.
  function automatic logic [4:0] digit_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b0, c[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      return 5'(c - 8'h61 + 8'd10);
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      return 5'(c - 8'h41 + 8'd10);
    end
    return 5'h10;
  endfunction

  task automatic await_result(logic [7:0] b, kind_t k, logic [3:0] code);
    unescaped_result_t r;
    r.out_byte = b;
    r.kind     = k;
    r.code     = code;
    r.last     = 1'b0;
    awaited_q.push_back(r);
    step_results++;
  endtask

  // An error item, after which the decoder goes back to waiting for a quote.
  task automatic await_error(logic [3:0] code);
    await_result(8'h00, KIND_ERR, code);
    parse_phase = PH_IDLE;
    digit_accum = '0;
    digit_count = '0;
    high_bits   = '0;
  endtask

  // A code point as one to four UTF-8 bytes.
  task automatic await_code_point(logic [20:0] cp);
    if (cp <= 21'h7F) begin
      await_result(cp[7:0], KIND_DATA, ERR_NONE);
    end else if (cp <= 21'h7FF) begin
      await_result({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
      await_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else if (cp <= 21'hFFFF) begin
      await_result({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
      await_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      await_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end else begin
      await_result({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
      await_result({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
      await_result({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
      await_result({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
    end
  endtask

  // Takes one hex digit; complete goes high when the fourth one arrives.
  task automatic gather_digit(logic [7:0] c, logic eot, output bit complete);
    logic [4:0] d;
    complete = 1'b0;
    d = digit_value(c);
    if (eot) begin
      await_error(ERR_TRUNC_U);
    end else if (d[4]) begin
      await_error(ERR_BAD_HEX);
    end else begin
      digit_accum = {digit_accum[11:0], d[3:0]};
      if (digit_count == 2'd3) begin
        digit_count = 2'd0;
        complete    = 1'b1;
      end else begin
        digit_count = digit_count + 2'd1;
      end
    end
  endtask

  // Predicts every result item that one source item causes.
  task automatic decode_source(logic [7:0] c, logic eot);
    bit                complete;
    logic [15:0]       v;
    unescaped_result_t r;
    step_results = 0;
    case (parse_phase)
      PH_BODY: begin
        if (eot) begin
          await_error(ERR_UNTERMINATED);
        end else if (c == CH_QUOTE) begin
          await_result(8'h00, KIND_DONE, ERR_NONE);
          parse_phase = PH_IDLE;
        end else if (c == CH_NL) begin
          await_error(ERR_RAW_NEWLINE);
        end else if (c == CH_BSLASH) begin
          parse_phase = PH_ESC;
        end else begin
          await_result(c, KIND_DATA, ERR_NONE);
        end
      end
      PH_ESC: begin
        if (eot) begin
          await_error(ERR_UNTERM_ESC);
        end else begin
          parse_phase = PH_BODY;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: await_result(c, KIND_DATA, ERR_NONE);
            CH_LOW_B: await_result(8'h08, KIND_DATA, ERR_NONE);
            CH_LOW_F: await_result(8'h0C, KIND_DATA, ERR_NONE);
            CH_LOW_N: await_result(8'h0A, KIND_DATA, ERR_NONE);
            CH_LOW_R: await_result(8'h0D, KIND_DATA, ERR_NONE);
            CH_LOW_T: await_result(8'h09, KIND_DATA, ERR_NONE);
            CH_LOW_U: begin
              parse_phase = PH_HEXHI;
              digit_accum = '0;
              digit_count = '0;
            end
            default: await_error(ERR_BAD_ESCAPE);
          endcase
        end
      end
      PH_HEXHI: begin
        gather_digit(c, eot, complete);
        if (complete) begin
          v = digit_accum;
          digit_accum = '0;
          if (v >= HIGH_SUR_MIN && v <= HIGH_SUR_MAX) begin
            high_bits   = v[9:0];
            parse_phase = PH_WANTBS;
          end else if (v >= LOW_SUR_MIN && v <= LOW_SUR_MAX) begin
            await_error(ERR_LONE_LOW);
          end else begin
            await_code_point({5'b0, v});
            parse_phase = PH_BODY;
          end
        end
      end
      PH_WANTBS: begin
        if (eot || c != CH_BSLASH) begin
          await_error(ERR_LONE_HIGH);
        end else begin
          parse_phase = PH_WANTU;
        end
      end
      PH_WANTU: begin
        if (eot || c != CH_LOW_U) begin
          await_error(ERR_LONE_HIGH);
        end else begin
          parse_phase = PH_HEXLO;
          digit_accum = '0;
          digit_count = '0;
        end
      end
      PH_HEXLO: begin
        gather_digit(c, eot, complete);
        if (complete) begin
          v = digit_accum;
          digit_accum = '0;
          if (v < LOW_SUR_MIN || v > LOW_SUR_MAX) begin
            await_error(ERR_INVALID_LOW);
          end else begin
            // The pair carries the ten bits of each half above 0x10000.
            await_code_point(21'h10000 + {1'b0, high_bits, v[9:0]});
            high_bits   = '0;
            parse_phase = PH_BODY;
          end
        end
      end
      default: begin
        if (!eot && c == CH_QUOTE) begin
          parse_phase = PH_BODY;
          digit_accum = '0;
          digit_count = '0;
          high_bits   = '0;
        end else begin
          await_error(ERR_EXPECT_QUOTE);
        end
      end
    endcase
    // The final item of this step carries the last flag.
    if (step_results > 0) begin
      r = awaited_q.pop_back();
      r.last = 1'b1;
      awaited_q.push_back(r);
    end
  endtask

  // Compare each accepted result first, then predict from the accepted source item.
  always @(posedge clk) begin
    unescaped_result_t e;
    if (rst) begin
      parse_phase = PH_IDLE;
      digit_accum = '0;
      digit_count = '0;
      high_bits   = '0;
      awaited_q.delete();
    end else begin
      if (pop && !empty) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected item: expected none, got byte %02h kind %0d code %0d last %0d",
                   $time, out_byte, kind, error_code, last);
          mismatches <= mismatches + 1;
        end else begin
          e = awaited_q.pop_front();
          if (out_byte !== e.out_byte || kind !== e.kind || error_code !== e.code ||
              last !== e.last) begin
            $display("%0t: item mismatch: expected byte %02h kind %0d code %0d last %0d,",
                     $time, e.out_byte, e.kind, e.code, e.last,
                     " got byte %02h kind %0d code %0d last %0d",
                     out_byte, kind, error_code, last);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (push && !full) begin
        decode_source(in_byte, end_of_text);
      end
    end
    pending_results <= awaited_q.size();
  end

endmodule

// File: tb/tb_top.sv
// Top of the testbench: clock, reset, source text stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_top;
  import jsu_pkg::*;

  localparam int RANDOM_ITEMS = 230;
  localparam int CALM_ITEMS   = 40;
  localparam int QUIET_LIMIT  = 500;

  // One source item: a text byte, or the end-of-text marker.
  typedef struct {
    logic [7:0] b;
    logic       eot;
  } source_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [3:0] error_code;
  logic       last;
  int         mismatches;
  int         pending_results;
  bit         calm = 1'b0;

  source_item_t text_q[$];

  always #6 clk = ~clk;

  json_string_unescape_utf8 i_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .kind        (kind),
    .error_code  (error_code),
    .last        (last)
  );

  utf8_unescape_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .in_byte         (in_byte),
    .end_of_text     (end_of_text),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .kind            (kind),
    .error_code      (error_code),
    .last            (last),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  task automatic put_byte(logic [7:0] b);
    source_item_t s;
    s.b   = b;
    s.eot = 1'b0;
    text_q.push_back(s);
  endtask

  // The byte lane carries noise with the end marker; the block must ignore it.
  task automatic put_eot();
    source_item_t s;
    s.b   = 8'($urandom_range(0, 255));
    s.eot = 1'b1;
    text_q.push_back(s);
  endtask

  function automatic bit is_hex_char(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic bit is_escape_char(logic [7:0] c);
    return c == CH_QUOTE || c == CH_BSLASH || c == CH_SLASH || c == CH_LOW_B ||
           c == CH_LOW_F || c == CH_LOW_N || c == CH_LOW_R || c == CH_LOW_T ||
           c == CH_LOW_U;
  endfunction

  // Any byte that passes straight through the string body.
  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_QUOTE || c == CH_BSLASH || c == CH_NL);
    return c;
  endfunction

  // A hex digit in random letter case.
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) begin
      return 8'h30 + 8'(n);
    end
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
  endfunction

  task automatic put_u_escape(logic [15:0] v);
    put_byte(CH_BSLASH);
    put_byte(CH_LOW_U);
    for (int k = 3; k >= 0; k--) begin
      put_byte(hex_char(v[4*k +: 4]));
    end
  endtask

  function automatic logic [15:0] high_surrogate();
    return HIGH_SUR_MIN + 16'($urandom_range(0, 16'h3FF));
  endfunction

  function automatic logic [15:0] low_surrogate();
    return LOW_SUR_MIN + 16'($urandom_range(0, 16'h3FF));
  endfunction

  // A code point below 0x10000 outside the surrogates, spread over the UTF-8 lengths.
  function automatic logic [15:0] plane0_code_point();
    logic [15:0] v;
    case ($urandom_range(0, 2))
      0: v = 16'($urandom_range(0, 16'h7F));
      1: v = 16'($urandom_range(16'h80, 16'h7FF));
      default: begin
        do v = 16'($urandom_range(16'h800, 16'hFFFF));
        while (v >= HIGH_SUR_MIN && v <= LOW_SUR_MAX);
      end
    endcase
    return v;
  endfunction

  task automatic put_simple_escape();
    put_byte(CH_BSLASH);
    case ($urandom_range(0, 7))
      0: put_byte(CH_QUOTE);
      1: put_byte(CH_BSLASH);
      2: put_byte(CH_SLASH);
      3: put_byte(CH_LOW_B);
      4: put_byte(CH_LOW_F);
      5: put_byte(CH_LOW_N);
      6: put_byte(CH_LOW_R);
      default: put_byte(CH_LOW_T);
    endcase
  endtask

  // A complete string with random content of every kind.
  task automatic put_good_string();
    int n;
    n = $urandom_range(0, 6);
    put_byte(CH_QUOTE);
    repeat (n) begin
      case ($urandom_range(0, 4))
        0, 1: put_byte(plain_byte());
        2: put_simple_escape();
        3: put_u_escape(plane0_code_point());
        default: begin
          put_u_escape(high_surrogate());
          put_u_escape(low_surrogate());
        end
      endcase
    end
    put_byte(CH_QUOTE);
  endtask

  // A string that breaks off with one of the error conditions, or noise before the opening quote.
  task automatic put_broken_string();
    logic [7:0]  c;
    logic [15:0] v;
    int          n;
    if ($urandom_range(0, 9) == 0) begin
      // Noise while waiting for the opening quote.
      if ($urandom_range(0, 1)) begin
        put_eot();
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE);
        put_byte(c);
      end
      return;
    end
    put_byte(CH_QUOTE);
    repeat ($urandom_range(0, 2)) put_byte(plain_byte());
    case ($urandom_range(0, 7))
      0: put_eot();
      1: put_byte(CH_NL);
      2: begin
        put_byte(CH_BSLASH);
        put_eot();
      end
      3: begin
        do c = 8'($urandom_range(0, 255));
        while (is_escape_char(c));
        put_byte(CH_BSLASH);
        put_byte(c);
      end
      4: begin
        // Cut short, or spoiled by a non-hex byte, inside the digits.
        v = plane0_code_point();
        n = $urandom_range(0, 3);
        put_byte(CH_BSLASH);
        put_byte(CH_LOW_U);
        for (int k = 0; k < n; k++) begin
          put_byte(hex_char(v[4*(3-k) +: 4]));
        end
        if ($urandom_range(0, 1)) begin
          put_eot();
        end else begin
          do c = 8'($urandom_range(0, 255));
          while (is_hex_char(c));
          put_byte(c);
        end
      end
      5: begin
        // High half not followed by a backslash and u.
        put_u_escape(high_surrogate());
        case ($urandom_range(0, 3))
          0: put_eot();
          1: begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_BSLASH);
            put_byte(c);
          end
          2: begin
            put_byte(CH_BSLASH);
            put_eot();
          end
          default: begin
            do c = 8'($urandom_range(0, 255));
            while (c == CH_LOW_U);
            put_byte(CH_BSLASH);
            put_byte(c);
          end
        endcase
      end
      6: begin
        // High half followed by something other than a low half.
        do v = 16'($urandom_range(0, 16'hFFFF));
        while (v >= LOW_SUR_MIN && v <= LOW_SUR_MAX);
        put_u_escape(high_surrogate());
        if ($urandom_range(0, 3) == 0) begin
          // Truncated second escape.
          put_byte(CH_BSLASH);
          put_byte(CH_LOW_U);
          put_byte(hex_char(v[15:12]));
          put_eot();
        end else begin
          put_u_escape(v);
        end
      end
      default: put_u_escape(low_surrogate());
    endcase
  endtask

  task automatic build_text();
    int target;
    // Idle noise: the top byte value and the end marker.
    put_byte(8'hFF);
    put_eot();
    // Body extremes, an escaped slash, then a raw newline.
    put_byte(CH_QUOTE);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(CH_BSLASH);
    put_byte(CH_SLASH);
    put_byte(CH_NL);
    // Highest code point as a surrogate pair, then the closing quote.
    put_byte(CH_QUOTE);
    put_u_escape(HIGH_SUR_MAX);
    put_u_escape(LOW_SUR_MAX);
    put_byte(CH_QUOTE);
    // Text ending inside the body.
    put_byte(CH_QUOTE);
    put_eot();
    // Mostly well-formed strings, the rest broken, up to the total item count.
    target = RANDOM_ITEMS;
    while (text_q.size() < target) begin
      if ($urandom_range(0, 99) < 70) begin
        put_good_string();
      end else begin
        put_broken_string();
      end
    end
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 20;
      default: return 50;
    endcase
  endfunction

  // Source side: push every item, with idle bursts until the last stretch.
  initial begin : source_side
    int gap_pct;
    gap_pct = 0;
    build_text();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < text_q.size(); i++) begin
      if (i % 30 == 0) begin
        gap_pct = pick_idle_pct();
      end
      calm = (text_q.size() - i <= CALM_ITEMS);
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      push        <= 1'b1;
      in_byte     <= text_q[i].b;
      end_of_text <= text_q[i].eot;
      @(posedge clk);
      while (full) @(posedge clk);
    end
    push <= 1'b0;
    // Let every predicted item come out, then allow for strays.
    do @(posedge clk);
    while (pending_results != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Result side: pop with stall bursts until the last stretch.
  initial begin : result_side
    int stall_pct;
    stall_pct = 0;
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        stall_pct = pick_idle_pct();
      end
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Ends the run when no item moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8.sv
tb/utf8_unescape_checker.sv
tb/tb_top.sv
